[src/fcsg_pkg.sv]
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types, constants and lookup tables of the four-channel sound unit.
// ----------------------------------------------------------------------------
package fcsg_pkg;

	localparam int unsigned FIFO_DEPTH = 4;

	localparam logic [14:0] FRAME_Q1 = 15'd3728;
	localparam logic [14:0] FRAME_Q2 = 15'd7456;
	localparam logic [14:0] FRAME_Q3 = 15'd11185;
	localparam logic [14:0] FRAME_Q4 = 15'd14914;
	localparam logic [14:0] FRAME_Q5 = 15'd18640;
	localparam logic [15:0] PERIOD_MAX = 16'h07FF;

	// register offsets
	localparam logic [4:0] REG_P1_CTL   = 5'h00;
	localparam logic [4:0] REG_P1_SWEEP = 5'h01;
	localparam logic [4:0] REG_P1_LO    = 5'h02;
	localparam logic [4:0] REG_P1_HI    = 5'h03;
	localparam logic [4:0] REG_P2_CTL   = 5'h04;
	localparam logic [4:0] REG_P2_SWEEP = 5'h05;
	localparam logic [4:0] REG_P2_LO    = 5'h06;
	localparam logic [4:0] REG_P2_HI    = 5'h07;
	localparam logic [4:0] REG_TRI_LIN  = 5'h08;
	localparam logic [4:0] REG_TRI_LO   = 5'h0A;
	localparam logic [4:0] REG_TRI_HI   = 5'h0B;
	localparam logic [4:0] REG_NZ_CTL   = 5'h0C;
	localparam logic [4:0] REG_NZ_MODE  = 5'h0E;
	localparam logic [4:0] REG_NZ_LEN   = 5'h0F;
	localparam logic [4:0] REG_STATUS   = 5'h15;
	localparam logic [4:0] REG_FRAME    = 5'h17;

	// classified item handed from front to back
	typedef struct packed {
		logic       is_write;
		logic [4:0] reg_offset;
		logic [7:0] reg_data;
	} item_t;

	function automatic logic [7:0] len_load(input logic [4:0] idx);
		logic [7:0] r;
		case (idx)
			5'd0: r = 8'd10;   5'd1: r = 8'd254;  5'd2: r = 8'd20;   5'd3: r = 8'd2;
			5'd4: r = 8'd40;   5'd5: r = 8'd4;    5'd6: r = 8'd80;   5'd7: r = 8'd6;
			5'd8: r = 8'd160;  5'd9: r = 8'd8;    5'd10: r = 8'd60;  5'd11: r = 8'd10;
			5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
			5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
			5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
			5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
			5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
		endcase
		return r;
	endfunction

	function automatic logic [11:0] noise_rate(input logic [3:0] idx);
		logic [11:0] r;
		case (idx)
			4'd0: r = 12'd4;     4'd1: r = 12'd8;     4'd2: r = 12'd16;    4'd3: r = 12'd32;
			4'd4: r = 12'd64;    4'd5: r = 12'd96;    4'd6: r = 12'd128;   4'd7: r = 12'd160;
			4'd8: r = 12'd202;   4'd9: r = 12'd254;   4'd10: r = 12'd380;  4'd11: r = 12'd508;
			4'd12: r = 12'd762;  4'd13: r = 12'd1016; 4'd14: r = 12'd2034; default: r = 12'd4068;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] duty_bits(input logic [1:0] d);
		logic [7:0] r;
		case (d)
			2'd0: r = 8'h02;
			2'd1: r = 8'h06;
			2'd2: r = 8'h1E;
			default: r = 8'hF9;
		endcase
		return r;
	endfunction

endpackage

[src/fcsg_front.sv]
// ----------------------------------------------------------------------------
// fcsg_front
// Input side: takes items and sorts them into ticks and register writes.
// ----------------------------------------------------------------------------
module fcsg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 op,
	input  logic [4:0]           reg_offset,
	input  logic [7:0]           reg_data,
	output logic                 item_valid,
	output fcsg_pkg::item_t      item,
	input  logic                 item_ready
);

	logic            valid_q;
	fcsg_pkg::item_t item_q;

	assign full       = valid_q && !item_ready;
	assign item_valid = valid_q;
	assign item       = item_q;

	// input register, classifies the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!full) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			item_q.is_write   <= op;
			item_q.reg_offset <= reg_offset;
			item_q.reg_data   <= reg_data;
		end
	end

endmodule

[src/fcsg_fifo.sv]
// ----------------------------------------------------------------------------
// fcsg_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module fcsg_fifo #(
	parameter int unsigned DEPTH = fcsg_pkg::FIFO_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  fcsg_pkg::item_t wr_item,
	output logic            rd_valid,
	input  logic            rd_ready,
	output fcsg_pkg::item_t rd_item
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	fcsg_pkg::item_t    mem_q [DEPTH];
	logic [AW-1:0]      wptr_q, rptr_q;
	logic [AW:0]        cnt_q;
	logic               do_wr, do_rd;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH)) || rd_ready;
	assign rd_valid = cnt_q != '0;
	assign rd_item  = mem_q[rptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_rd) rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wr_item;
	end

endmodule

[src/fcsg_back.sv]
// ----------------------------------------------------------------------------
// fcsg_back
// Channel state: applies writes and ticks, registers the channel levels.
// ----------------------------------------------------------------------------
module fcsg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  fcsg_pkg::item_t item,
	output logic            empty,
	input  logic            pop,
	output logic [3:0]      pulse1_level,
	output logic [3:0]      pulse2_level,
	output logic [3:0]      triangle_level,
	output logic [3:0]      noise_level,
	output logic [3:0]      length_status
);

	// architectural state
	logic [15:0] pper_q [2];
	logic [15:0] pcnt_q [2];
	logic [2:0]  pstep_q [2];
	logic [1:0]  pduty_q [2];
	logic        phalt_q [2], pconst_q [2], swen_q [2], swneg_q [2];
	logic [3:0]  pvol_q [2];
	logic [2:0]  swper_q [2], swsh_q [2];
	logic        penv_st_q [2];
	logic [3:0]  penv_div_q [2], penv_lvl_q [2];
	logic [2:0]  swdiv_q [2];
	logic        swrel_q [2];
	logic [7:0]  len_q [4];
	logic [3:0]  en_q;
	logic [10:0] tper_q, tcnt_q;
	logic [4:0]  tstep_q;
	logic [6:0]  lin_cnt_q, lin_per_q;
	logic        lin_rel_q, lin_halt_q;
	logic [11:0] nper_q, ncnt_q;
	logic        nmode_q;
	logic [14:0] nsh_q;
	logic        nhalt_q, nconst_q;
	logic [3:0]  nvol_q;
	logic        nenv_st_q;
	logic [3:0]  nenv_div_q, nenv_lvl_q;
	logic [14:0] fcnt_q;
	logic        five_q, par_q;

	logic        out_valid_q;
	logic [3:0]  p1_q, p2_q, tri_q, nz_q, st_q;

	logic        go;

	assign empty      = !out_valid_q;
	assign item_ready = !out_valid_q || pop;
	assign go         = item_valid && item_ready;

	assign pulse1_level   = p1_q;
	assign pulse2_level   = p2_q;
	assign triangle_level = tri_q;
	assign noise_level    = nz_q;
	assign length_status  = st_q;

	// next-state computation
	logic [15:0] n_pper [2];
	logic [15:0] n_pcnt [2];
	logic [2:0]  n_pstep [2];
	logic [1:0]  n_pduty [2];
	logic        n_phalt [2], n_pconst [2], n_swen [2], n_swneg [2];
	logic [3:0]  n_pvol [2];
	logic [2:0]  n_swper [2], n_swsh [2];
	logic        n_penv_st [2];
	logic [3:0]  n_penv_div [2], n_penv_lvl [2];
	logic [2:0]  n_swdiv [2];
	logic        n_swrel [2];
	logic [7:0]  n_len [4];
	logic [3:0]  n_en;
	logic [10:0] n_tper, n_tcnt;
	logic [4:0]  n_tstep;
	logic [6:0]  n_lin_cnt, n_lin_per;
	logic        n_lin_rel, n_lin_halt;
	logic [11:0] n_nper, n_ncnt;
	logic        n_nmode;
	logic [14:0] n_nsh;
	logic        n_nhalt, n_nconst;
	logic [3:0]  n_nvol;
	logic        n_nenv_st;
	logic [3:0]  n_nenv_div, n_nenv_lvl;
	logic [14:0] n_fcnt;
	logic        n_five, n_par;
	logic [3:0]  o_p1, o_p2, o_tri, o_nz, o_st;

	always_comb begin
		logic qf, hf, fb;
		logic [15:0] delta;
		logic [15:0] p;
		logic [4:0]  s;
		logic        hlt [4];
		logic [7:0]  db0, db1;
		// hold by default
		for (int c = 0; c < 2; c++) begin
			n_pper[c] = pper_q[c];   n_pcnt[c] = pcnt_q[c];   n_pstep[c] = pstep_q[c];
			n_pduty[c] = pduty_q[c]; n_phalt[c] = phalt_q[c]; n_pconst[c] = pconst_q[c];
			n_pvol[c] = pvol_q[c];   n_swen[c] = swen_q[c];   n_swneg[c] = swneg_q[c];
			n_swper[c] = swper_q[c]; n_swsh[c] = swsh_q[c];   n_penv_st[c] = penv_st_q[c];
			n_penv_div[c] = penv_div_q[c]; n_penv_lvl[c] = penv_lvl_q[c];
			n_swdiv[c] = swdiv_q[c]; n_swrel[c] = swrel_q[c];
		end
		for (int c = 0; c < 4; c++) n_len[c] = len_q[c];
		for (int c = 0; c < 4; c++) hlt[c] = 1'b0;
		n_en = en_q; n_tper = tper_q; n_tcnt = tcnt_q; n_tstep = tstep_q;
		n_lin_cnt = lin_cnt_q; n_lin_per = lin_per_q; n_lin_rel = lin_rel_q;
		n_lin_halt = lin_halt_q; n_nper = nper_q; n_ncnt = ncnt_q; n_nmode = nmode_q;
		n_nsh = nsh_q; n_nhalt = nhalt_q; n_nconst = nconst_q; n_nvol = nvol_q;
		n_nenv_st = nenv_st_q; n_nenv_div = nenv_div_q; n_nenv_lvl = nenv_lvl_q;
		n_fcnt = fcnt_q; n_five = five_q; n_par = par_q;
		qf = 1'b0;
		hf = 1'b0;
		fb = 1'b0;
		delta = '0;
		p = '0;
		s = '0;

		if (item.is_write) begin
			// register write decode
			case (item.reg_offset)
				fcsg_pkg::REG_P1_CTL, fcsg_pkg::REG_P2_CTL: begin
					n_pduty[item.reg_offset[2]]  = item.reg_data[7:6];
					n_phalt[item.reg_offset[2]]  = item.reg_data[5];
					n_pconst[item.reg_offset[2]] = item.reg_data[4];
					n_pvol[item.reg_offset[2]]   = item.reg_data[3:0];
				end
				fcsg_pkg::REG_P1_SWEEP, fcsg_pkg::REG_P2_SWEEP: begin
					n_swen[item.reg_offset[2]]  = item.reg_data[7];
					n_swper[item.reg_offset[2]] = item.reg_data[6:4];
					n_swneg[item.reg_offset[2]] = item.reg_data[3];
					n_swsh[item.reg_offset[2]]  = item.reg_data[2:0];
					n_swrel[item.reg_offset[2]] = 1'b1;
				end
				fcsg_pkg::REG_P1_LO, fcsg_pkg::REG_P2_LO: begin
					n_pper[item.reg_offset[2]][7:0] = item.reg_data;
				end
				fcsg_pkg::REG_P1_HI, fcsg_pkg::REG_P2_HI: begin
					n_pper[item.reg_offset[2]][15:8] = {5'd0, item.reg_data[2:0]};
					n_len[item.reg_offset[2]]        = fcsg_pkg::len_load(item.reg_data[7:3]);
					n_penv_st[item.reg_offset[2]]    = 1'b1;
					n_pstep[item.reg_offset[2]]      = '0;
				end
				fcsg_pkg::REG_TRI_LIN: begin
					n_lin_halt = item.reg_data[7];
					n_lin_per  = item.reg_data[6:0];
				end
				fcsg_pkg::REG_TRI_LO: n_tper[7:0] = item.reg_data;
				fcsg_pkg::REG_TRI_HI: begin
					n_tper[10:8] = item.reg_data[2:0];
					n_len[2]     = fcsg_pkg::len_load(item.reg_data[7:3]);
					n_lin_rel    = 1'b1;
				end
				fcsg_pkg::REG_NZ_CTL: begin
					n_nhalt  = item.reg_data[5];
					n_nconst = item.reg_data[4];
					n_nvol   = item.reg_data[3:0];
				end
				fcsg_pkg::REG_NZ_MODE: begin
					n_nmode = item.reg_data[7];
					n_nper  = fcsg_pkg::noise_rate(item.reg_data[3:0]);
				end
				fcsg_pkg::REG_NZ_LEN: begin
					n_len[3]  = fcsg_pkg::len_load(item.reg_data[7:3]);
					n_nenv_st = 1'b1;
				end
				fcsg_pkg::REG_STATUS: begin
					for (int c = 0; c < 4; c++) begin
						n_en[c] = item.reg_data[c];
						if (!item.reg_data[c]) n_len[c] = '0;
					end
				end
				fcsg_pkg::REG_FRAME: begin
					n_five = item.reg_data[7];
					n_fcnt = '0;
					hf = item.reg_data[7];
					qf = item.reg_data[7];
				end
				default: ;
			endcase
		end else begin
			// frame sequencer
			n_par = !par_q;
			if (fcnt_q == fcsg_pkg::FRAME_Q1 || fcnt_q == fcsg_pkg::FRAME_Q3) begin
				qf = 1'b1;
				n_fcnt = fcnt_q + 15'd1;
			end else if (fcnt_q == fcsg_pkg::FRAME_Q2) begin
				qf = 1'b1;
				hf = 1'b1;
				n_fcnt = fcnt_q + 15'd1;
			end else if (fcnt_q == (five_q ? fcsg_pkg::FRAME_Q5 : fcsg_pkg::FRAME_Q4)) begin
				qf = 1'b1;
				hf = 1'b1;
				n_fcnt = '0;
			end else begin
				n_fcnt = fcnt_q + 15'd1;
			end
			// noise timer on odd ticks
			if (n_par) begin
				if (ncnt_q == '0) begin
					fb     = nmode_q ? (nsh_q[6] ^ nsh_q[0]) : (nsh_q[1] ^ nsh_q[0]);
					n_ncnt = nper_q;
					n_nsh  = {fb, nsh_q[14:1]};
				end else begin
					n_ncnt = ncnt_q - 12'd1;
				end
			end
			// triangle timer
			if (tcnt_q == '0) begin
				n_tcnt  = tper_q;
				n_tstep = tstep_q + 5'd1;
			end else begin
				n_tcnt = tcnt_q - 11'd1;
			end
		end

		// half frame: lengths and sweeps (uses state after the write)
		if (hf) begin
			hlt[0] = n_phalt[0];
			hlt[1] = n_phalt[1];
			hlt[2] = n_lin_halt;
			hlt[3] = n_nhalt;
			for (int c = 0; c < 4; c++) begin
				if (!hlt[c] && n_len[c] != '0) n_len[c] = n_len[c] - 8'd1;
			end
			for (int c = 0; c < 2; c++) begin
				p = n_pper[c];
				if (n_swdiv[c] == '0 && n_swen[c] && p >= 16'd8) begin
					delta = p >> n_swsh[c];
					if (n_swneg[c]) n_pper[c] = p - (c != 0 ? delta : delta + 16'd1);
					else            n_pper[c] = p + delta;
				end
				if (n_swdiv[c] == '0 || n_swrel[c]) begin
					n_swdiv[c] = n_swper[c];
					n_swrel[c] = 1'b0;
				end else begin
					n_swdiv[c] = n_swdiv[c] - 3'd1;
				end
			end
		end

		// pulse timers on odd ticks, reload from the period after any sweep
		if (!item.is_write && n_par) begin
			for (int c = 0; c < 2; c++) begin
				if (pcnt_q[c] == '0) begin
					n_pcnt[c]  = n_pper[c];
					n_pstep[c] = pstep_q[c] + 3'd1;
				end else begin
					n_pcnt[c] = pcnt_q[c] - 16'd1;
				end
			end
		end

		// quarter frame: envelopes and linear counter
		if (qf) begin
			for (int c = 0; c < 2; c++) begin
				if (n_penv_st[c]) begin
					n_penv_lvl[c] = 4'd15;
					n_penv_div[c] = n_pvol[c];
					n_penv_st[c]  = 1'b0;
				end else if (n_penv_div[c] != '0) begin
					n_penv_div[c] = n_penv_div[c] - 4'd1;
				end else begin
					n_penv_div[c] = n_pvol[c];
					if (n_penv_lvl[c] != '0) n_penv_lvl[c] = n_penv_lvl[c] - 4'd1;
					else if (n_phalt[c])     n_penv_lvl[c] = 4'd15;
				end
			end
			if (n_lin_rel) n_lin_cnt = n_lin_per;
			else if (n_lin_cnt != '0) n_lin_cnt = n_lin_cnt - 7'd1;
			if (!n_lin_halt) n_lin_rel = 1'b0;
			if (n_nenv_st) begin
				n_nenv_lvl = 4'd15;
				n_nenv_div = n_nvol;
				n_nenv_st  = 1'b0;
			end else if (n_nenv_div != '0) begin
				n_nenv_div = n_nenv_div - 4'd1;
			end else begin
				n_nenv_div = n_nvol;
				if (n_nenv_lvl != '0) n_nenv_lvl = n_nenv_lvl - 4'd1;
				else if (n_nhalt)     n_nenv_lvl = 4'd15;
			end
		end

		// levels from the new state
		db0 = fcsg_pkg::duty_bits(n_pduty[0]);
		db1 = fcsg_pkg::duty_bits(n_pduty[1]);
		o_p1 = '0;
		o_p2 = '0;
		if (n_en[0] && n_len[0] != '0 && n_pper[0] >= 16'd8 && n_pper[0] <= fcsg_pkg::PERIOD_MAX
			&& db0[n_pstep[0]])
			o_p1 = n_pconst[0] ? n_pvol[0] : n_penv_lvl[0];
		if (n_en[1] && n_len[1] != '0 && n_pper[1] >= 16'd8 && n_pper[1] <= fcsg_pkg::PERIOD_MAX
			&& db1[n_pstep[1]])
			o_p2 = n_pconst[1] ? n_pvol[1] : n_penv_lvl[1];
		o_tri = '0;
		if (n_en[2] && n_len[2] != '0 && n_lin_cnt != '0) begin
			s = n_tstep;
			o_tri = s[4] ? s[3:0] : ~s[3:0];
		end
		o_nz = '0;
		if (n_en[3] && n_len[3] != '0 && !n_nsh[0]) o_nz = n_nconst ? n_nvol : n_nenv_lvl;
		for (int c = 0; c < 4; c++) o_st[c] = n_len[c] != '0;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				pper_q[c] <= '0; pcnt_q[c] <= '0; pstep_q[c] <= '0; pduty_q[c] <= '0;
				phalt_q[c] <= 1'b0; pconst_q[c] <= 1'b0; pvol_q[c] <= '0; swen_q[c] <= 1'b0;
				swneg_q[c] <= 1'b0; swper_q[c] <= '0; swsh_q[c] <= '0; penv_st_q[c] <= 1'b0;
				penv_div_q[c] <= '0; penv_lvl_q[c] <= '0; swdiv_q[c] <= '0; swrel_q[c] <= 1'b0;
			end
			for (int c = 0; c < 4; c++) len_q[c] <= '0;
			en_q <= '0; tper_q <= '0; tcnt_q <= '0; tstep_q <= '0;
			lin_cnt_q <= '0; lin_per_q <= '0; lin_rel_q <= 1'b0; lin_halt_q <= 1'b0;
			nper_q <= '0; ncnt_q <= '0; nmode_q <= 1'b0; nsh_q <= 15'd1;
			nhalt_q <= 1'b0; nconst_q <= 1'b0; nvol_q <= '0;
			nenv_st_q <= 1'b0; nenv_div_q <= '0; nenv_lvl_q <= '0;
			fcnt_q <= '0; five_q <= 1'b0; par_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				for (int c = 0; c < 2; c++) begin
					pper_q[c] <= n_pper[c]; pcnt_q[c] <= n_pcnt[c]; pstep_q[c] <= n_pstep[c];
					pduty_q[c] <= n_pduty[c]; phalt_q[c] <= n_phalt[c];
					pconst_q[c] <= n_pconst[c]; pvol_q[c] <= n_pvol[c]; swen_q[c] <= n_swen[c];
					swneg_q[c] <= n_swneg[c]; swper_q[c] <= n_swper[c]; swsh_q[c] <= n_swsh[c];
					penv_st_q[c] <= n_penv_st[c]; penv_div_q[c] <= n_penv_div[c];
					penv_lvl_q[c] <= n_penv_lvl[c]; swdiv_q[c] <= n_swdiv[c];
					swrel_q[c] <= n_swrel[c];
				end
				for (int c = 0; c < 4; c++) len_q[c] <= n_len[c];
				en_q <= n_en; tper_q <= n_tper; tcnt_q <= n_tcnt; tstep_q <= n_tstep;
				lin_cnt_q <= n_lin_cnt; lin_per_q <= n_lin_per; lin_rel_q <= n_lin_rel;
				lin_halt_q <= n_lin_halt; nper_q <= n_nper; ncnt_q <= n_ncnt;
				nmode_q <= n_nmode; nsh_q <= n_nsh; nhalt_q <= n_nhalt;
				nconst_q <= n_nconst; nvol_q <= n_nvol; nenv_st_q <= n_nenv_st;
				nenv_div_q <= n_nenv_div; nenv_lvl_q <= n_nenv_lvl;
				fcnt_q <= n_fcnt; five_q <= n_five; par_q <= n_par;
			end
			if (go)       out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (go) begin
			p1_q  <= o_p1;
			p2_q  <= o_p2;
			tri_q <= o_tri;
			nz_q  <= o_nz;
			st_q  <= o_st;
		end
	end

endmodule

[src/four_channel_sound_generator.sv]
// Path: an item passes the input register, the queue and the channel-state
// update, in that order, before its result is ready.
// Throughput: one item per cycle while the result register is empty or popped;
// the channel-state update in the back part settles each item combinationally.
// Reset: arst_n clears all channel state (noise shifter to one), the input register and the queue.
// ----------------------------------------------------------------------------
// four_channel_sound_generator
// Two pulse, one triangle and one noise channel with a frame sequencer.
// ----------------------------------------------------------------------------
module four_channel_sound_generator #(
	parameter int unsigned FIFO_DEPTH = fcsg_pkg::FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       op,
	input  logic [4:0] reg_offset,
	input  logic [7:0] reg_data,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] pulse1_level,
	output logic [3:0] pulse2_level,
	output logic [3:0] triangle_level,
	output logic [3:0] noise_level,
	output logic [3:0] length_status
);

	logic            f_valid, f_ready, b_valid, b_ready;
	fcsg_pkg::item_t f_item, b_item;

	fcsg_front u_front (
		.clk, .arst_n, .push, .full, .op, .reg_offset, .reg_data,
		.item_valid(f_valid), .item(f_item), .item_ready(f_ready)
	);

	fcsg_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
	);

	fcsg_back u_back (
		.clk, .arst_n,
		.item_valid(b_valid), .item_ready(b_ready), .item(b_item),
		.empty, .pop, .pulse1_level, .pulse2_level, .triangle_level,
		.noise_level, .length_status
	);

endmodule
